>>> sv/bcbp_pkg.sv
// Shared types, constants and helpers for the bipartite component best pair block.
// No dependencies; used by bipartite_component_best_pair.
package bcbp_pkg;

    localparam int NodeW = 10;
    localparam int CfgW = 11;
    localparam int PairW = 12;
    localparam int OptW = 11;
    localparam int CountW = 12;
    localparam int InDataW = 24;
    localparam int OutDataW = 88;
    localparam logic [CfgW-1:0] NumNodesRst = 11'd1024;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLR,
        ST_E_RD,
        ST_E_CHK,
        ST_FA_RD,
        ST_FA_CHK,
        ST_FB_RD,
        ST_FB_CHK,
        ST_S1_RD,
        ST_S1_CHK,
        ST_S2_RD,
        ST_S2_CHK,
        ST_OUT
    } state_t;

    // Lexicographic (high, low) compare.
    function automatic logic pair_gt(input int h1, input int l1, input int h2, input int l2);
        pair_gt = (h1 > h2) || ((h1 == h2) && (l1 > l2));
    endfunction

endpackage

>>> sv/bipartite_component_best_pair.sv
// Top level of the bipartite component best pair block: edge loading and sequencer.
// Depends on bcbp_pkg and bcbp_ram.
//
// Edges stream in one item per cycle while s_tready is high; each is stored in the
// edge memory (items beyond MAX_EDGES are dropped). The item with s_tlast set starts
// the computation and s_tready stays low until the single result item has been taken
// on the master side. The computation runs on single-port-read memories, one access
// per cycle: a clearing pass over the parent and best-value tables, then per stored
// edge a fetch, plus for an edge in range a read per vertex visited on each of the
// two root walks (union-find without rank, so walks grow with tree depth), then a
// root walk for each of the 2*n vertices, then a scan over all 2*n vertices for the
// roots. The registered memory read on each parent hop sets the pace. num_nodes is
// sampled at the last edge; 0 acts as 1 and values above MAX_NODES act as
// MAX_NODES. Edges with an index not below n are ignored.
module bipartite_component_best_pair #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: num_nodes
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    // edge items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] left_node, [19:10] right_node, rest zero
    input  logic        s_tlast,   // last_edge
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [11:0] design_high, [23:12] design_low,
                                   // [35:24] edge_best_high, [47:36] edge_best_low,
                                   // [58:48] optimum_high, [69:59] optimum_low,
                                   // [70] optimum_reached, [71] design_success,
                                   // [72] fully_connected, [84:73] component_count
);
    localparam int VW = $clog2(2 * MAX_NODES);
    localparam int SW = VW + 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW = 2 * bcbp_pkg::NodeW;

    bcbp_pkg::state_t state_reg, state_next;

    logic [bcbp_pkg::CfgW-1:0] num_nodes_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [VW:0]     v_reg, v_next;
    logic [VW-1:0]   cur_reg, cur_next;
    logic [VW-1:0]   ra_reg, ra_next;
    logic [VW-1:0]   rv_reg, rv_next;
    logic [VW-1:0]   n_reg, n_next;
    logic [VW:0]     comps_reg, comps_next;
    logic signed [SW-1:0] eh_reg, eh_next, el_reg, el_next;
    logic signed [SW-1:0] dh_reg, dh_next, dl_reg, dl_next;

    // memory ports
    logic            e_we;
    logic [AW-1:0]   e_raddr;
    logic [EW-1:0]   e_q;
    logic            p_we;
    logic [VW-1:0]   p_waddr, p_wdata, p_raddr, p_q;
    logic            bl_we, br_we;
    logic [VW-1:0]   b_waddr, b_raddr;
    logic signed [SW-1:0] bl_wdata, br_wdata, bl_q, br_q;

    logic            s_acc, m_acc;
    logic [bcbp_pkg::NodeW-1:0] e_l, e_r;
    logic [VW:0]     nv;
    logic            last_v;
    logic            last_k;
    int              n_clamp;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == bcbp_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == bcbp_pkg::ST_OUT);
    assign e_we = s_acc && (32'(cnt_reg) < MAX_EDGES);
    assign e_l = e_q[bcbp_pkg::NodeW-1:0];
    assign e_r = e_q[EW-1:bcbp_pkg::NodeW];
    assign nv = {n_reg, 1'b0};
    assign last_v = (v_reg + 1'b1 == nv);
    assign last_k = (k_reg + 1'b1 == cnt_reg);

    // clamp the register into 1..MAX_NODES
    always_comb
    begin
        if (num_nodes_reg == '0)
            n_clamp = 1;
        else if (32'(num_nodes_reg) > MAX_NODES)
            n_clamp = MAX_NODES;
        else
            n_clamp = 32'(num_nodes_reg);
    end

    bcbp_ram #(.W(EW), .D(MAX_EDGES)) u_edge_ram (
        .clk(clk), .wr_en(e_we), .wr_addr(cnt_reg[AW-1:0]), .wr_data(s_tdata[EW-1:0]),
        .rd_addr(e_raddr), .rd_data(e_q)
    );
    bcbp_ram #(.W(VW), .D(2 * MAX_NODES)) u_parent_ram (
        .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
        .rd_addr(p_raddr), .rd_data(p_q)
    );
    bcbp_ram #(.W(SW), .D(2 * MAX_NODES)) u_best_l_ram (
        .clk(clk), .wr_en(bl_we), .wr_addr(b_waddr), .wr_data(bl_wdata),
        .rd_addr(b_raddr), .rd_data(bl_q)
    );
    bcbp_ram #(.W(SW), .D(2 * MAX_NODES)) u_best_r_ram (
        .clk(clk), .wr_en(br_we), .wr_addr(b_waddr), .wr_data(br_wdata),
        .rd_addr(b_raddr), .rd_data(br_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcbp_pkg::ST_LOAD;
            num_nodes_reg <= bcbp_pkg::NumNodesRst;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (cfg_we)
            begin
                num_nodes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        v_reg <= v_next;
        cur_reg <= cur_next;
        ra_reg <= ra_next;
        rv_reg <= rv_next;
        n_reg <= n_next;
        comps_reg <= comps_next;
        eh_reg <= eh_next;
        el_reg <= el_next;
        dh_reg <= dh_next;
        dl_reg <= dl_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        v_next = v_reg;
        cur_next = cur_reg;
        ra_next = ra_reg;
        rv_next = rv_reg;
        n_next = n_reg;
        comps_next = comps_reg;
        eh_next = eh_reg;
        el_next = el_reg;
        dh_next = dh_reg;
        dl_next = dl_reg;
        e_raddr = k_reg[AW-1:0];
        p_we = 1'b0;
        p_waddr = v_reg[VW-1:0];
        p_wdata = v_reg[VW-1:0];
        p_raddr = cur_reg;
        bl_we = 1'b0;
        br_we = 1'b0;
        b_waddr = v_reg[VW-1:0];
        b_raddr = v_reg[VW-1:0];
        bl_wdata = '1;
        br_wdata = '1;

        unique case (state_reg)
            bcbp_pkg::ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (e_we)
                        cnt_next = cnt_reg + 1'b1;
                    if (s_tlast)
                    begin
                        // latch n and start the clearing pass
                        n_next = VW'(n_clamp);
                        v_next = '0;
                        k_next = '0;
                        comps_next = (VW + 1)'(2 * n_clamp);
                        eh_next = '1;
                        el_next = '1;
                        dh_next = '1;
                        dl_next = '1;
                        state_next = bcbp_pkg::ST_CLR;
                    end
                end
            end
            bcbp_pkg::ST_CLR:
            begin
                // each vertex its own root, no best values
                p_we = 1'b1;
                bl_we = 1'b1;
                br_we = 1'b1;
                v_next = v_reg + 1'b1;
                if (last_v)
                begin
                    v_next = '0;
                    cur_next = '0;
                    state_next = (cnt_reg == '0) ? bcbp_pkg::ST_S1_RD : bcbp_pkg::ST_E_RD;
                end
            end
            bcbp_pkg::ST_E_RD:
            begin
                state_next = bcbp_pkg::ST_E_CHK;
            end
            bcbp_pkg::ST_E_CHK:
            begin
                if (32'(e_l) < 32'(n_reg) && 32'(e_r) < 32'(n_reg))
                begin
                    rv_next = VW'(32'(e_r) + 32'(n_reg));
                    cur_next = VW'(e_l);
                    // right value always exceeds left value
                    if (bcbp_pkg::pair_gt(32'(e_r) + 32'(n_reg), 32'(e_l),
                                          32'(eh_reg), 32'(el_reg)))
                    begin
                        eh_next = SW'(32'(e_r) + 32'(n_reg));
                        el_next = SW'(e_l);
                    end
                    state_next = bcbp_pkg::ST_FA_RD;
                end
                else if (last_k)
                begin
                    cur_next = '0;
                    state_next = bcbp_pkg::ST_S1_RD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = bcbp_pkg::ST_E_RD;
                end
            end
            bcbp_pkg::ST_FA_RD:
            begin
                state_next = bcbp_pkg::ST_FA_CHK;
            end
            bcbp_pkg::ST_FA_CHK:
            begin
                if (p_q == cur_reg)
                begin
                    ra_next = cur_reg;
                    cur_next = rv_reg;
                    state_next = bcbp_pkg::ST_FB_RD;
                end
                else
                begin
                    cur_next = p_q;
                    state_next = bcbp_pkg::ST_FA_RD;
                end
            end
            bcbp_pkg::ST_FB_RD:
            begin
                state_next = bcbp_pkg::ST_FB_CHK;
            end
            bcbp_pkg::ST_FB_CHK:
            begin
                if (p_q == cur_reg)
                begin
                    // link the two roots
                    if (ra_reg != cur_reg)
                    begin
                        p_we = 1'b1;
                        p_waddr = ra_reg;
                        p_wdata = cur_reg;
                        comps_next = comps_reg - 1'b1;
                    end
                    if (last_k)
                    begin
                        cur_next = '0;
                        state_next = bcbp_pkg::ST_S1_RD;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = bcbp_pkg::ST_E_RD;
                    end
                end
                else
                begin
                    cur_next = p_q;
                    state_next = bcbp_pkg::ST_FB_RD;
                end
            end
            bcbp_pkg::ST_S1_RD:
            begin
                state_next = bcbp_pkg::ST_S1_CHK;
            end
            bcbp_pkg::ST_S1_CHK:
            begin
                if (p_q == cur_reg)
                begin
                    // vertices come in rising order, so the last write is the maximum
                    b_waddr = cur_reg;
                    bl_wdata = SW'(v_reg);
                    br_wdata = SW'(v_reg);
                    if (32'(v_reg) < 32'(n_reg))
                        bl_we = 1'b1;
                    else
                        br_we = 1'b1;
                    v_next = v_reg + 1'b1;
                    cur_next = VW'(v_reg + 1'b1);
                    if (last_v)
                    begin
                        v_next = '0;
                        state_next = bcbp_pkg::ST_S2_RD;
                    end
                    else
                    begin
                        state_next = bcbp_pkg::ST_S1_RD;
                    end
                end
                else
                begin
                    cur_next = p_q;
                    state_next = bcbp_pkg::ST_S1_RD;
                end
            end
            bcbp_pkg::ST_S2_RD:
            begin
                p_raddr = v_reg[VW-1:0];
                state_next = bcbp_pkg::ST_S2_CHK;
            end
            bcbp_pkg::ST_S2_CHK:
            begin
                if (p_q == v_reg[VW-1:0] && bl_q >= 0 && br_q >= 0)
                begin
                    if (bcbp_pkg::pair_gt(32'(br_q), 32'(bl_q), 32'(dh_reg), 32'(dl_reg)))
                    begin
                        dh_next = br_q;
                        dl_next = bl_q;
                    end
                end
                v_next = v_reg + 1'b1;
                state_next = last_v ? bcbp_pkg::ST_OUT : bcbp_pkg::ST_S2_RD;
            end
            bcbp_pkg::ST_OUT:
            begin
                if (m_acc)
                begin
                    cnt_next = '0;
                    state_next = bcbp_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = bcbp_pkg::ST_LOAD;
            end
        endcase
    end

    // result assembly from the held registers
    logic signed [SW:0] opt_h, opt_l;
    logic reached, success;

    assign opt_h = (SW + 1)'(2 * 32'(n_reg) - 1);
    assign opt_l = (SW + 1)'(32'(n_reg) - 1);
    assign reached = (32'(dh_reg) == 32'(opt_h)) && (32'(dl_reg) == 32'(opt_l));
    assign success = reached ||
                     bcbp_pkg::pair_gt(32'(dh_reg), 32'(dl_reg), 32'(eh_reg), 32'(el_reg));

    assign m_tdata[11:0]  = bcbp_pkg::PairW'(dh_reg);
    assign m_tdata[23:12] = bcbp_pkg::PairW'(dl_reg);
    assign m_tdata[35:24] = bcbp_pkg::PairW'(eh_reg);
    assign m_tdata[47:36] = bcbp_pkg::PairW'(el_reg);
    assign m_tdata[58:48] = bcbp_pkg::OptW'(opt_h);
    assign m_tdata[69:59] = bcbp_pkg::OptW'(opt_l);
    assign m_tdata[70]    = reached;
    assign m_tdata[71]    = success;
    assign m_tdata[72]    = (comps_reg == (VW + 1)'(1));
    assign m_tdata[84:73] = bcbp_pkg::CountW'(comps_reg);
    assign m_tdata[87:85] = '0;

    // never take an edge while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("edge and result channels active together");

    // stored edge count never exceeds the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_EDGES)
        else $error("edge count beyond store depth");

    // a taken result returns the block to loading with an empty store
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (s_tready && cnt_reg == '0))
        else $error("store not emptied after result");

    // a last edge always starts the clearing pass
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == bcbp_pkg::ST_CLR))
        else $error("last edge did not start computation");
endmodule

>>> sv/bcbp_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bcbp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] wr_addr,
    input  logic [W-1:0]                  wr_data,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] rd_addr,
    output logic [W-1:0]                  rd_data
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
